[hw/rtl/est_pkg.sv]
// est_pkg: shared types, codes and constants for the endpoint set table.
// Used by est_ctrl, est_dpath and endpoint_set_table; depends on nothing.
package est_pkg;

    localparam int DEPTH_DEFAULT = 16;
    // Most recipients listed for one notify item.
    localparam int MAX_RESULTS   = 16;
    localparam int EMIT_W        = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] CMD_LOOKUP     = 3'd0;
    localparam logic [2:0] CMD_ADD        = 3'd1;
    localparam logic [2:0] CMD_REMOVE     = 3'd2;
    localparam logic [2:0] CMD_NOTIFY_ON  = 3'd3;
    localparam logic [2:0] CMD_NOTIFY_OFF = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DUP      = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] ip_address;
        logic [15:0] port_number;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        recipient_valid;
        logic [31:0] recipient_address;
        logic [15:0] recipient_port;
        logic        notice_kind;
        logic        last_result;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_REPLY,
        S_EMIT_RD,
        S_EMIT_WR
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic scan;
        logic shift_start;
        logic shift;
        logic emit_start;
        logic rd;
        logic reply;
        logic emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] command;
        logic       found;
        logic       walk_done;
        logic       none_left;
        logic       skip;
        logic       emit_last;
        logic       out_free;
    } t_sts;

endpackage

[hw/rtl/endpoint_set_table.sv]
// endpoint_set_table: top level of the insertion-ordered endpoint set.
// Depends on est_pkg, est_ctrl and est_dpath.
//
//   channel  | valid       | stall        | payload
//   ---------+-------------+--------------+------------------------------
//   input    | i_in_valid  | o_in_stall   | i_in_data  (t_in_item)
//   output   | o_out_valid | i_out_stall  | o_out_data (t_out_item)
//
// Every item first scans the stored entries through the single read port of
// the entry memory. Lookup, add and unknown commands then pass through the
// decide and reply states; a remove that finds its entry first moves every
// later entry down by one place to close the gap.
// Notify lists the entries in turn, bar the excluded one, as stalls allow.
// Reset empties the table at once; no clearing pass is needed.
// A new item is taken while the last result of the previous one still waits.
module endpoint_set_table #(
    parameter int DEPTH = est_pkg::DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  est_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output est_pkg::t_out_item o_out_data
);

    est_pkg::t_cmd cmd;
    est_pkg::t_sts sts;

    est_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    est_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

[hw/rtl/est_ctrl.sv]
// est_ctrl: sequencing state machine of the endpoint set table.
// Depends on est_pkg; drives est_dpath through est_pkg::t_cmd.
module est_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  est_pkg::t_sts i_sts,
    output est_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    est_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= est_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            est_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = est_pkg::S_SCAN;
                end
            end
            est_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = est_pkg::S_DECIDE;
                end
            end
            est_pkg::S_DECIDE: begin
                if (i_sts.command == est_pkg::CMD_REMOVE && i_sts.found) begin
                    o_cmd.shift_start = 1'b1;
                    n_state           = est_pkg::S_SHIFT;
                end else if (i_sts.command inside {est_pkg::CMD_NOTIFY_ON,
                                                   est_pkg::CMD_NOTIFY_OFF}
                             && !i_sts.none_left) begin
                    o_cmd.emit_start = 1'b1;
                    n_state          = est_pkg::S_EMIT_RD;
                end else begin
                    n_state = est_pkg::S_REPLY;
                end
            end
            est_pkg::S_SHIFT: begin
                // close the gap left by the removed entry
                o_cmd.shift = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = est_pkg::S_REPLY;
                end
            end
            est_pkg::S_REPLY: begin
                if (i_sts.out_free) begin
                    o_cmd.reply = 1'b1;
                    n_state     = est_pkg::S_IDLE;
                end
            end
            est_pkg::S_EMIT_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = est_pkg::S_EMIT_WR;
            end
            est_pkg::S_EMIT_WR: begin
                // drop the excluded endpoint, hold the others until the slot frees
                if (i_sts.skip) begin
                    n_state = est_pkg::S_EMIT_RD;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.emit_last ? est_pkg::S_IDLE : est_pkg::S_EMIT_RD;
                end
            end
            default: begin
                n_state = est_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/est_dpath.sv]
// est_dpath: entry memory, walk pointer, match search and output register.
// Depends on est_pkg; commanded by est_ctrl.
module est_dpath #(
    parameter int DEPTH = est_pkg::DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  est_pkg::t_in_item   i_in_data,
    input  est_pkg::t_cmd       i_cmd,
    input  logic                i_out_stall,
    output est_pkg::t_sts       o_sts,
    output logic                o_out_valid,
    output est_pkg::t_out_item  o_out_data
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = est_pkg::EMIT_W;
    localparam int TW = (CW > EW) ? CW : EW;

    logic [47:0]        r_mem [DEPTH];
    est_pkg::t_in_item  r_item;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_ptr;
    logic               r_rd_vld;
    logic [IW-1:0]      r_rd_idx;
    logic [47:0]        r_rd_data;
    logic               r_found;
    logic [IW-1:0]      r_match_idx;
    logic [EW-1:0]      r_total;
    logic [EW-1:0]      r_emitted;
    logic               r_out_vld;
    est_pkg::t_out_item r_out;

    logic [47:0]        key;
    logic               in_range;
    logic               rd_en;
    logic               is_full;
    logic               add_ok;
    logic               rm_ok;
    logic               hit;
    logic               kind;
    logic               emit_last;
    logic               out_free;
    logic [TW-1:0]      rest;
    logic [TW-1:0]      capped;
    est_pkg::t_out_item reply_item;
    est_pkg::t_out_item emit_item;

    assign key       = {r_item.ip_address, r_item.port_number};
    assign in_range  = r_ptr < r_count;
    assign rd_en     = ((i_cmd.scan | i_cmd.shift) & in_range) | i_cmd.rd;
    assign is_full   = r_count == CW'(DEPTH);
    assign add_ok    = (r_item.command == est_pkg::CMD_ADD) && !r_found && !is_full;
    assign rm_ok     = (r_item.command == est_pkg::CMD_REMOVE) && r_found;
    assign hit       = i_cmd.scan && r_rd_vld && !r_found && (r_rd_data == key);
    assign kind      = r_item.command == est_pkg::CMD_NOTIFY_OFF;
    assign emit_last = (r_emitted + EW'(1)) == r_total;
    assign out_free  = !r_out_vld || !i_out_stall;
    assign rest      = TW'(r_count) - TW'(r_found);
    assign capped    = (rest > TW'(est_pkg::MAX_RESULTS)) ? TW'(est_pkg::MAX_RESULTS) : rest;

    always_comb begin
        reply_item             = '0;
        reply_item.last_result = 1'b1;
        reply_item.notice_kind = kind;
        case (r_item.command)
            est_pkg::CMD_LOOKUP: begin
                reply_item.status = r_found ? est_pkg::ST_OK : est_pkg::ST_NOTFOUND;
            end
            est_pkg::CMD_ADD: begin
                reply_item.status = r_found ? est_pkg::ST_DUP :
                                    is_full ? est_pkg::ST_FULL : est_pkg::ST_OK;
            end
            est_pkg::CMD_REMOVE: begin
                reply_item.status = r_found ? est_pkg::ST_OK : est_pkg::ST_NOTFOUND;
            end
            default: begin
                reply_item.status = est_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        emit_item                   = '0;
        emit_item.status            = est_pkg::ST_OK;
        emit_item.recipient_valid   = 1'b1;
        emit_item.recipient_address = r_rd_data[47:16];
        emit_item.recipient_port    = r_rd_data[15:0];
        emit_item.notice_kind       = kind;
        emit_item.last_result       = emit_last;
    end

    always_comb begin
        o_sts           = '0;
        o_sts.command   = r_item.command;
        o_sts.found     = r_found;
        o_sts.walk_done = !in_range && !r_rd_vld;
        o_sts.none_left = rest == '0;
        o_sts.skip      = r_found && (r_rd_idx == r_match_idx);
        o_sts.emit_last = emit_last;
        o_sts.out_free  = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            if (i_cmd.reply && add_ok) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.reply && rm_ok) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.load_item) begin
                r_found <= 1'b0;
            end else if (hit) begin
                r_found <= 1'b1;
            end
            if (i_cmd.reply || i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_data;
        end
        if (i_cmd.load_item || i_cmd.emit_start) begin
            r_ptr <= '0;
        end else if (i_cmd.shift_start) begin
            r_ptr <= CW'(r_match_idx) + CW'(1);
        end else if (rd_en) begin
            r_ptr <= r_ptr + CW'(1);
        end
        if (hit) begin
            r_match_idx <= r_rd_idx;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_ptr[IW-1:0]];
            r_rd_idx  <= r_ptr[IW-1:0];
        end
        // move each later entry down by one place
        if (i_cmd.shift && r_rd_vld) begin
            r_mem[r_rd_idx - IW'(1)] <= r_rd_data;
        end else if (i_cmd.reply && add_ok) begin
            r_mem[r_count[IW-1:0]] <= key;
        end
        if (i_cmd.emit_start) begin
            r_total   <= capped[EW-1:0];
            r_emitted <= '0;
        end else if (i_cmd.emit) begin
            r_emitted <= r_emitted + EW'(1);
        end
        if (i_cmd.reply) begin
            r_out <= reply_item;
        end else if (i_cmd.emit) begin
            r_out <= emit_item;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_read_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (r_ptr < r_count))
        else $error("read of an entry beyond the table");

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_emitted < r_total))
        else $error("notify listed more recipients than counted");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.reply && add_ok) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("accepted add did not grow the table");

endmodule
